>>> design/segint_pkg.sv
package segint_pkg;

  // Orientations tested per pair: (A, B start), (A, B end), (B, A start), (B, A end)
  localparam int NUM_ORIENT = 4;
  // Two cross-product terms per orientation
  localparam int NUM_PROD = 2 * NUM_ORIENT;

  typedef logic [NUM_ORIENT-1:0] orient_flags_t;

  // Per-orientation result of the cross-product compare
  typedef struct packed {
    orient_flags_t zero;  // collinear
    orient_flags_t pos;   // strictly left
  } orient_t;

endpackage

>>> design/segint_prep.sv
module segint_prep #(
  parameter int CW = 32
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic signed [CW-1:0]                        a_start_x,
  input  logic signed [CW-1:0]                        a_start_y,
  input  logic signed [CW-1:0]                        a_end_x,
  input  logic signed [CW-1:0]                        a_end_y,
  input  logic signed [CW-1:0]                        b_start_x,
  input  logic signed [CW-1:0]                        b_start_y,
  input  logic signed [CW-1:0]                        b_end_x,
  input  logic signed [CW-1:0]                        b_end_y,
  output logic [segint_pkg::NUM_PROD-1:0][CW-1:0]     opnd_a,
  output logic [segint_pkg::NUM_PROD-1:0][CW-1:0]     opnd_b,
  output logic [segint_pkg::NUM_PROD-1:0]             prod_neg,
  output segint_pkg::orient_flags_t                   in_box
);
  import segint_pkg::*;

  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  logic [NUM_PROD-1:0][CW-1:0] opnd_a_next;
  logic [NUM_PROD-1:0][CW-1:0] opnd_b_next;
  logic [NUM_PROD-1:0]         prod_neg_next;
  orient_flags_t               in_box_next;

  // Differences span CW+1 bits but their magnitude always fits in CW bits
  function automatic logic [CW-1:0] mag_of(input logic [CW:0] d);
    logic [CW:0] n;
    n = d[CW] ? (~d + 1'b1) : d;
    return n[CW-1:0];
  endfunction

  assign px[0] = a_start_x;
  assign py[0] = a_start_y;
  assign px[1] = a_end_x;
  assign py[1] = a_end_y;
  assign px[2] = b_start_x;
  assign py[2] = b_start_y;
  assign px[3] = b_end_x;
  assign py[3] = b_end_y;

  for (genvar i = 0; i < NUM_ORIENT; i++) begin : g_orient
    // cross (a - o) x (r - o): segment o->a, test point r
    localparam int OI = (i < 2) ? 0 : 2;
    localparam int AI = OI + 1;
    localparam int RI = (i < 2) ? i + 2 : i - 2;

    logic [CW:0] dx1, dy1, dx2, dy2;
    logic        bx, by;

    assign dx1 = {px[AI][CW-1], px[AI]} - {px[OI][CW-1], px[OI]};
    assign dy1 = {py[AI][CW-1], py[AI]} - {py[OI][CW-1], py[OI]};
    assign dx2 = {px[RI][CW-1], px[RI]} - {px[OI][CW-1], px[OI]};
    assign dy2 = {py[RI][CW-1], py[RI]} - {py[OI][CW-1], py[OI]};

    assign opnd_a_next[2*i]     = mag_of(dx1);
    assign opnd_b_next[2*i]     = mag_of(dy2);
    assign prod_neg_next[2*i]   = dx1[CW] ^ dy2[CW];
    assign opnd_a_next[2*i+1]   = mag_of(dy1);
    assign opnd_b_next[2*i+1]   = mag_of(dx2);
    assign prod_neg_next[2*i+1] = dy1[CW] ^ dx2[CW];

    assign bx = ((px[OI] <= px[RI]) && (px[RI] <= px[AI]))
             || ((px[AI] <= px[RI]) && (px[RI] <= px[OI]));
    assign by = ((py[OI] <= py[RI]) && (py[RI] <= py[AI]))
             || ((py[AI] <= py[RI]) && (py[RI] <= py[OI]));
    assign in_box_next[i] = bx & by;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opnd_a   <= opnd_a_next;
      opnd_b   <= opnd_b_next;
      prod_neg <= prod_neg_next;
      in_box   <= in_box_next;
    end
  end

endmodule

>>> design/segint_mul.sv
module segint_mul #(
  parameter int MW = 32
) (
  input  logic            clk,
  input  logic            en_pp,
  input  logic            en_sum,
  input  logic [MW-1:0]   a,
  input  logic [MW-1:0]   b,
  input  logic            neg_in,
  output logic [2*MW-1:0] prod,
  output logic            neg
);
  localparam int LO = MW / 2;
  localparam int HI = MW - LO;

  // Partial products, registered before the sum
  logic [2*LO-1:0]  pp_ll;
  logic [LO+HI-1:0] pp_lh;
  logic [LO+HI-1:0] pp_hl;
  logic [2*HI-1:0]  pp_hh;
  logic             neg_pp;

  logic [LO+HI:0]   mid;
  logic [2*MW-1:0]  prod_next;

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_ll  <= a[LO-1:0] * b[LO-1:0];
      pp_lh  <= a[LO-1:0] * b[MW-1:LO];
      pp_hl  <= a[MW-1:LO] * b[LO-1:0];
      pp_hh  <= a[MW-1:LO] * b[MW-1:LO];
      neg_pp <= neg_in;
    end
  end

  assign mid       = {1'b0, pp_lh} + {1'b0, pp_hl};
  assign prod_next = {pp_hh, pp_ll} + ({{(MW-1){1'b0}}, mid} << LO);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      prod <= prod_next;
      neg  <= neg_pp;
    end
  end

endmodule

>>> design/segint_decide.sv
module segint_decide #(
  parameter int CW = 32
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic [segint_pkg::NUM_PROD-1:0][2*CW-1:0]   prod,
  input  logic [segint_pkg::NUM_PROD-1:0]             prod_neg,
  input  segint_pkg::orient_flags_t                   in_box,
  output logic                                        intersects
);
  import segint_pkg::*;

  orient_t orient;
  logic    hit;

  // Sign-magnitude compare of the two cross-product terms
  for (genvar i = 0; i < NUM_ORIENT; i++) begin : g_cmp
    logic nl, nr, gt_m, eq_m;

    assign nl   = prod_neg[2*i]   & (|prod[2*i]);
    assign nr   = prod_neg[2*i+1] & (|prod[2*i+1]);
    assign gt_m = prod[2*i] > prod[2*i+1];
    assign eq_m = prod[2*i] == prod[2*i+1];

    assign orient.zero[i] = (nl == nr) & eq_m;
    assign orient.pos[i]  = (nl != nr) ? nr : (nl ? (~gt_m & ~eq_m) : gt_m);
  end

  // endpoint touching the other segment, else a proper straddle both ways
  assign hit = (|(orient.zero & in_box))
            || ((orient.pos[0] != orient.pos[1]) && (orient.pos[2] != orient.pos[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      intersects <= hit;
    end
  end

endmodule

>>> design/segment_intersection_test_unit.sv
// Closed segment intersection test for two integer segments A and B. Each input
// word carries both segments as four signed endpoints; each output word is one
// flag that is 1 when the segments share a point (touching and collinear overlap
// included). Fully pipelined: one pair per cycle while the output is not stalled.
// After the input register, the depth is set by the cross products: differences,
// then registered half-width partial products, then their sum, then the sign
// compare and decision. A stage holds its word while the next is full and stalled,
// so in_ready drops only when every stage is full and the output is stalled.
module segment_intersection_test_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_start_x,
  input  logic signed [COORD_WIDTH-1:0] a_start_y,
  input  logic signed [COORD_WIDTH-1:0] a_end_x,
  input  logic signed [COORD_WIDTH-1:0] a_end_y,
  input  logic signed [COORD_WIDTH-1:0] b_start_x,
  input  logic signed [COORD_WIDTH-1:0] b_start_y,
  input  logic signed [COORD_WIDTH-1:0] b_end_x,
  input  logic signed [COORD_WIDTH-1:0] b_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          intersects
);
  import segint_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0] in_asx, in_asy, in_aex, in_aey;
  logic signed [CW-1:0] in_bsx, in_bsy, in_bex, in_bey;

  logic v0, v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [NUM_PROD-1:0][CW-1:0]   opnd_a, opnd_b;
  logic [NUM_PROD-1:0]           neg1, neg3;
  logic [NUM_PROD-1:0][2*CW-1:0] prod;
  orient_flags_t                 box1, box2, box3;

  assign rdy4     = ~out_valid | out_ready;
  assign rdy3     = ~v3 | rdy4;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign in_ready = ~v0 | rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_asx <= a_start_x;
      in_asy <= a_start_y;
      in_aex <= a_end_x;
      in_aey <= a_end_y;
      in_bsx <= b_start_x;
      in_bsy <= b_start_y;
      in_bex <= b_end_x;
      in_bey <= b_end_y;
    end
  end

  segint_prep #(.CW(CW)) u_prep (
    .clk       (clk),
    .en        (rdy1),
    .a_start_x (in_asx),
    .a_start_y (in_asy),
    .a_end_x   (in_aex),
    .a_end_y   (in_aey),
    .b_start_x (in_bsx),
    .b_start_y (in_bsy),
    .b_end_x   (in_bex),
    .b_end_y   (in_bey),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b),
    .prod_neg  (neg1),
    .in_box    (box1)
  );

  for (genvar p = 0; p < NUM_PROD; p++) begin : g_mul
    segint_mul #(.MW(CW)) u_mul (
      .clk    (clk),
      .en_pp  (rdy2),
      .en_sum (rdy3),
      .a      (opnd_a[p]),
      .b      (opnd_b[p]),
      .neg_in (neg1[p]),
      .prod   (prod[p]),
      .neg    (neg3[p])
    );
  end

  // bounding-box flags ride alongside the multiplier stages
  always_ff @(posedge clk) begin
    if (rdy2) box2 <= box1;
    if (rdy3) box3 <= box2;
  end

  segint_decide #(.CW(CW)) u_decide (
    .clk        (clk),
    .en         (rdy4),
    .prod       (prod),
    .prod_neg   (neg3),
    .in_box     (box3),
    .intersects (intersects)
  );

endmodule

>>> design/segint_checker.sv
module segint_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic intersects
);

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(intersects))
    else $error("result word changed while stalled");

  // the pipeline only backs up from a blocked output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked output");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // no result can appear before a word has crossed the whole pipeline
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid [*4])
    else $error("result too soon after reset");

endmodule

bind segment_intersection_test_unit segint_checker u_segint_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .intersects (intersects)
);
